>>> hw/rtl/jpeg_sof_dimension_extract_defines.svh
// Assertion macros shared by the RTL files.
// Each macro expects signals named clock and reset in the using module.
`ifndef JPEG_SOF_DIMENSION_EXTRACT_DEFINES_SVH
`define JPEG_SOF_DIMENSION_EXTRACT_DEFINES_SVH

// Same-cycle implication.
`define JSDE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define JSDE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/jsde_pkg.sv
package jsde_pkg;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MARKER_W    = 16;
   localparam int DIM_W       = 16;
   localparam int OFFSET_W    = 32;

   localparam logic [MARKER_W-1:0] START_MARKER_RST = 16'hFFD8;
   localparam logic [MARKER_W-1:0] FRAME_MARKER_RST = 16'hFFC0;
   localparam logic [15:0]         LEN_MIN          = 16'd2;
   localparam logic [15:0]         FHDR_SKIP        = 16'd3;

   typedef enum logic {
      REG_START = 1'b0,
      REG_FRAME = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_BADSTART = 2'd1,
      ST_NOFRAME  = 2'd2
   } status_type;

   typedef enum logic [12:0] {
      PH_SOI0 = 13'b0000000000001,
      PH_SOI1 = 13'b0000000000010,
      PH_MK0  = 13'b0000000000100,
      PH_MK1  = 13'b0000000001000,
      PH_LEN0 = 13'b0000000010000,
      PH_LEN1 = 13'b0000000100000,
      PH_SKIP = 13'b0000001000000,
      PH_FHDR = 13'b0000010000000,
      PH_H0   = 13'b0000100000000,
      PH_H1   = 13'b0001000000000,
      PH_W0   = 13'b0010000000000,
      PH_W1   = 13'b0100000000000,
      PH_DONE = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [MARKER_W-1:0] start_marker;
      logic [MARKER_W-1:0] frame_marker;
   } csr_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [OFFSET_W-1:0] frame_offset;
   } result_type;

endpackage

>>> hw/rtl/jsde_csr.sv
module jsde_csr
   import jsde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output csr_type               cfg
);

   csr_type       cfg_ff;
   csr_type       cfg_in;
   reg_index_type index;

   assign index  = reg_index_type'(paddr[2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (index)
            REG_START: cfg_in.start_marker = pwdata[MARKER_W-1:0];
            REG_FRAME: cfg_in.frame_marker = pwdata[MARKER_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_START: prdata = CSR_DATA_W'(cfg_ff.start_marker);
         REG_FRAME: prdata = CSR_DATA_W'(cfg_ff.frame_marker);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= START_MARKER_RST;
         cfg_ff.frame_marker <= FRAME_MARKER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/jsde_parser.sv
`include "jpeg_sof_dimension_extract_defines.svh"

module jsde_parser
   import jsde_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] item_byte,
   input  logic       item_last,
   input  csr_type    cfg,
   output result_type result
);

   phase_type              phase_ff,  phase_in;
   logic [7:0]             prev_ff,   prev_in;
   logic [15:0]            skip_ff,   skip_in;
   logic [OFFSET_BITS-1:0] pos_ff,    pos_in;
   logic [OFFSET_BITS-1:0] seg_ff,    seg_in;
   logic [DIM_W-1:0]       height_ff, height_in;
   logic [15:0]            word;
   result_type             res;

   assign word   = {prev_ff, item_byte};
   assign result = res;

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      skip_in   = skip_ff;
      pos_in    = OFFSET_BITS'(pos_ff + 1'b1);
      seg_in    = seg_ff;
      height_in = height_ff;
      res       = '0;
      case (phase_ff)
         PH_SOI0: begin
            prev_in  = item_byte;
            phase_in = PH_SOI1;
         end
         PH_SOI1: begin
            prev_in = word[7:0];
            if (word == cfg.start_marker) begin
               phase_in = PH_MK0;
            end else begin
               res.valid  = 1'b1;
               res.status = ST_BADSTART;
               phase_in   = PH_DONE;
            end
         end
         PH_MK0: begin
            seg_in   = pos_ff;
            prev_in  = item_byte;
            phase_in = PH_MK1;
         end
         PH_MK1: begin
            prev_in = word[7:0];
            if (word == cfg.frame_marker) begin
               skip_in  = FHDR_SKIP;
               phase_in = PH_FHDR;
            end else begin
               phase_in = PH_LEN0;
            end
         end
         PH_LEN0: begin
            prev_in  = item_byte;
            phase_in = PH_LEN1;
         end
         PH_LEN1: begin
            prev_in = word[7:0];
            if (word <= LEN_MIN) begin
               phase_in = PH_MK0;
            end else begin
               skip_in  = word - LEN_MIN;
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 1'b1;
            if (skip_ff == 16'd1) begin
               phase_in = PH_MK0;
            end
         end
         PH_FHDR: begin
            skip_in = skip_ff - 1'b1;
            if (skip_ff == 16'd1) begin
               phase_in = PH_H0;
            end
         end
         PH_H0: begin
            prev_in  = item_byte;
            phase_in = PH_H1;
         end
         PH_H1: begin
            height_in = word;
            prev_in   = word[7:0];
            phase_in  = PH_W0;
         end
         PH_W0: begin
            prev_in  = item_byte;
            phase_in = PH_W1;
         end
         PH_W1: begin
            res.valid        = 1'b1;
            res.status       = ST_FOUND;
            res.image_width  = word;
            res.image_height = height_ff;
            res.frame_offset = OFFSET_W'(seg_ff);
            phase_in         = PH_DONE;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // end of stream: report if still pending, then rearm
      if (item_last) begin
         if (!res.valid && (phase_ff != PH_DONE)) begin
            res.valid  = 1'b1;
            res.status = ((phase_in == PH_SOI0) || (phase_in == PH_SOI1)) ?
                         ST_BADSTART : ST_NOFRAME;
         end
         phase_in  = PH_SOI0;
         prev_in   = '0;
         skip_in   = '0;
         pos_in    = '0;
         seg_in    = '0;
         height_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SOI0;
         prev_ff   <= '0;
         skip_ff   <= '0;
         pos_ff    <= '0;
         seg_ff    <= '0;
         height_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         seg_ff    <= seg_in;
         height_ff <= height_in;
      end
   end

   `JSDE_ASSERT_NXT(a_rearm, step_en && item_last, phase_ff == PH_SOI0)
   `JSDE_ASSERT_IMP(a_res_src, res.valid, (phase_ff == PH_SOI1) || (phase_ff == PH_W1) || item_last)
   `JSDE_ASSERT_NXT(a_done_hold, step_en && (phase_ff == PH_DONE) && !item_last, phase_ff == PH_DONE)

endmodule

>>> hw/rtl/jpeg_sof_dimension_extract.sv
// JPEG start-of-frame dimension extractor.
// req channel: one stream byte per item in req_tdata[7:0], req_tlast on the
// final byte of the file. rsp channel: at most one item per file carrying
// status in rsp_tuser and width, height and frame marker offset in rsp_tdata.
// csr port: start marker at byte address 0, frame marker at 4 (16 bits each).
// Throughput: one byte per cycle while rsp is not stalled.
// Data path: an accepted byte sits in the input register, is parsed by the
// marker state machine when the parser advances, and its result lands in the
// output register, which drives rsp.
// A stalled rsp item holds; the input register then fills and req_tready
// drops until the output register is taken.
// Reset empties both registers, rearms the parser and restores the marker
// defaults. req_tlast rearms the parser for the next file; bytes after a
// result up to req_tlast give no item. Byte offsets wrap at 2^OFFSET_BITS.
`include "jpeg_sof_dimension_extract_defines.svh"

module jpeg_sof_dimension_extract
   import jsde_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tlast,   // end_of_stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // image_width, image_height, frame_offset
   output logic [1:0]            rsp_tuser,   // status
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type res;
   csr_type    cfg;
   logic       advance;

   jsde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   jsde_parser #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item_byte (in_data_ff),
      .item_last (in_last_ff),
      .cfg       (cfg),
      .result    (res)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {out_ff.frame_offset, out_ff.image_height, out_ff.image_width};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && res.valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && res.valid) begin
         out_ff <= res;
      end
   end

   `JSDE_ASSERT_IMP(a_miss_zero, rsp_tvalid && (rsp_tuser != ST_FOUND), rsp_tdata == '0)
   `JSDE_ASSERT_NXT(a_res_load, advance && res.valid, rsp_tvalid)
   `JSDE_ASSERT_NXT(a_in_hold, in_valid_ff && !advance, in_valid_ff)

endmodule

>>> dv/jpeg_sof_dimension_extract_tb.sv
`timescale 1ns / 100ps

module jpeg_sof_dimension_extract_tb;
   import jsde_pkg::*;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned PHASE_BYTES  = 310;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned SETTLE       = 6;

   typedef struct packed {
      status_type          status;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [OFFSET_W-1:0] offset;
   } dims_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       pinned;
      dims_type   pin;
   } stream_byte_type;

   localparam dims_type NO_DIMS       = '{ST_FOUND, 16'h0, 16'h0, 32'h0};
   localparam dims_type BADSTART_DIMS = '{ST_BADSTART, 16'h0, 16'h0, 32'h0};
   localparam dims_type NOFRAME_DIMS  = '{ST_NOFRAME, 16'h0, 16'h0, 32'h0};

   localparam int N_DIRECTED = 23;
   localparam stream_byte_type DIRECTED_BYTES [N_DIRECTED] = '{
      '{8'hFF, 1'b1, 1'b1, BADSTART_DIMS},
      '{8'h00, 1'b0, 1'b0, NO_DIMS},
      '{8'h12, 1'b0, 1'b1, BADSTART_DIMS},
      '{8'hAB, 1'b0, 1'b0, NO_DIMS},
      '{8'hCD, 1'b1, 1'b0, NO_DIMS},
      '{8'hFF, 1'b0, 1'b0, NO_DIMS},
      '{8'hD8, 1'b0, 1'b0, NO_DIMS},
      '{8'hFF, 1'b0, 1'b0, NO_DIMS},
      '{8'hE0, 1'b0, 1'b0, NO_DIMS},
      '{8'h00, 1'b0, 1'b0, NO_DIMS},
      '{8'h01, 1'b0, 1'b0, NO_DIMS},
      '{8'hFF, 1'b0, 1'b0, NO_DIMS},
      '{8'hC0, 1'b0, 1'b0, NO_DIMS},
      '{8'h00, 1'b0, 1'b0, NO_DIMS},
      '{8'h11, 1'b0, 1'b0, NO_DIMS},
      '{8'h08, 1'b0, 1'b0, NO_DIMS},
      '{8'hFF, 1'b0, 1'b0, NO_DIMS},
      '{8'hFF, 1'b0, 1'b0, NO_DIMS},
      '{8'h00, 1'b0, 1'b0, NO_DIMS},
      '{8'h00, 1'b1, 1'b1, '{ST_FOUND, 16'h0000, 16'hFFFF, 32'd6}},
      '{8'hFF, 1'b0, 1'b0, NO_DIMS},
      '{8'hD8, 1'b0, 1'b0, NO_DIMS},
      '{8'hFF, 1'b1, 1'b1, NOFRAME_DIMS}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   jpeg_sof_dimension_extract u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // parser mirror
   logic [MARKER_W-1:0] cfg_start = START_MARKER_RST;
   logic [MARKER_W-1:0] cfg_frame = FRAME_MARKER_RST;
   phase_type           scan_phase = PH_SOI0;
   logic [15:0]         tail_bytes;
   logic [15:0]         bytes_left;
   logic [OFFSET_W-1:0] stream_pos;
   logic [OFFSET_W-1:0] marker_pos;
   logic [DIM_W-1:0]    held_height;
   bit                  reported;

   stream_byte_type byte_q[$];
   dims_type        dims_q[$];
   stream_byte_type cur_byte;
   bit           req_taken;
   bit           stall_hold;
   int unsigned  send_idle_pct = 24;
   int unsigned  recv_idle_pct = 52;
   int unsigned  mismatches;
   int unsigned  bytes_in;
   int unsigned  streams_sent;
   int unsigned  found_cnt;
   int unsigned  badstart_cnt;
   int unsigned  noframe_cnt;

   function automatic void rearm_parser();
      scan_phase  = PH_SOI0;
      tail_bytes  = '0;
      bytes_left  = '0;
      stream_pos  = '0;
      marker_pos  = '0;
      held_height = '0;
      reported    = 1'b0;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input bit eos, output dims_type r);
      logic [15:0] word;
      bit          made;
      word = {tail_bytes[7:0], b};
      made = 1'b0;
      r = NO_DIMS;
      if (!reported) begin
         case (scan_phase)
            PH_SOI0: begin
               tail_bytes = {8'h00, b};
               scan_phase = PH_SOI1;
            end
            PH_SOI1: begin
               tail_bytes = word;
               if (word == cfg_start) begin
                  scan_phase = PH_MK0;
               end else begin
                  r = BADSTART_DIMS;
                  made = 1'b1;
                  reported = 1'b1;
                  scan_phase = PH_DONE;
               end
            end
            PH_MK0: begin
               marker_pos = stream_pos;
               tail_bytes = {8'h00, b};
               scan_phase = PH_MK1;
            end
            PH_MK1: begin
               tail_bytes = word;
               if (word == cfg_frame) begin
                  bytes_left = FHDR_SKIP;
                  scan_phase = PH_FHDR;
               end else begin
                  scan_phase = PH_LEN0;
               end
            end
            PH_LEN0: begin
               tail_bytes = {8'h00, b};
               scan_phase = PH_LEN1;
            end
            PH_LEN1: begin
               tail_bytes = word;
               if (word <= LEN_MIN) begin
                  scan_phase = PH_MK0;
               end else begin
                  bytes_left = word - LEN_MIN;
                  scan_phase = PH_SKIP;
               end
            end
            PH_SKIP: begin
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == '0) scan_phase = PH_MK0;
            end
            PH_FHDR: begin
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == '0) scan_phase = PH_H0;
            end
            PH_H0: begin
               tail_bytes = {8'h00, b};
               scan_phase = PH_H1;
            end
            PH_H1: begin
               held_height = word;
               scan_phase = PH_W0;
            end
            PH_W0: begin
               tail_bytes = {8'h00, b};
               scan_phase = PH_W1;
            end
            PH_W1: begin
               r.status = ST_FOUND;
               r.width  = word;
               r.height = held_height;
               r.offset = marker_pos;
               made = 1'b1;
               reported = 1'b1;
               scan_phase = PH_DONE;
            end
            default: begin
               scan_phase = PH_DONE;
            end
         endcase
      end
      stream_pos = stream_pos + 1'b1;
      if (eos) begin
         if (!made && !reported) begin
            if (scan_phase == PH_SOI0 || scan_phase == PH_SOI1) begin
               r = BADSTART_DIMS;
            end else begin
               r = NOFRAME_DIMS;
            end
            made = 1'b1;
         end
         rearm_parser();
      end
      return made;
   endfunction

   function automatic logic [15:0] pick_dim();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // build one file: mostly well-formed, some cut short, some with a bad start, some noise
   task automatic queue_stream(output int unsigned n);
      logic [7:0]      s[$];
      logic [15:0]     mk;
      logic [15:0]     len;
      logic [15:0]     dim;
      int unsigned     kind;
      int unsigned     cut;
      int unsigned     i;
      stream_byte_type it;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(6, 1)) s.push_back(8'($urandom));
      end else begin
         s.push_back(cfg_start[15:8]);
         s.push_back(cfg_start[7:0]);
         repeat ($urandom_range(3)) begin
            mk = {8'hFF, 8'($urandom)};
            if ($urandom_range(9) == 0) mk = 16'($urandom);
            if (mk == cfg_frame) mk = mk ^ 16'h0001;
            len = 16'($urandom_range(9));
            if (len > 16'd3) len = 16'($urandom_range(40, 4));
            s.push_back(mk[15:8]);
            s.push_back(mk[7:0]);
            s.push_back(len[15:8]);
            s.push_back(len[7:0]);
            if (len > LEN_MIN) repeat (len - LEN_MIN) s.push_back(8'($urandom));
         end
         s.push_back(cfg_frame[15:8]);
         s.push_back(cfg_frame[7:0]);
         repeat (3) s.push_back(8'($urandom));
         dim = pick_dim();
         s.push_back(dim[15:8]);
         s.push_back(dim[7:0]);
         dim = pick_dim();
         s.push_back(dim[15:8]);
         s.push_back(dim[7:0]);
         repeat ($urandom_range(4)) s.push_back(8'($urandom));
         if (kind < 18) begin
            s[1] = s[1] ^ 8'($urandom_range(255, 1));
         end else if (kind < 36) begin
            cut = $urandom_range(s.size() - 1, 1);
            while (s.size() > cut) void'(s.pop_back());
         end
      end
      for (i = 0; i < s.size(); i++) begin
         it.data   = s[i];
         it.last   = (i == s.size() - 1);
         it.pinned = 1'b0;
         it.pin    = NO_DIMS;
         byte_q.push_back(it);
      end
      n = s.size();
      streams_sent++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [MARKER_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_START) begin
         cfg_start = value;
      end else begin
         cfg_frame = value;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      while (byte_q.size() != 0 || req_tvalid || dims_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [MARKER_W-1:0] start_m, input logic [MARKER_W-1:0] frame_m,
                            input int unsigned sidle, input int unsigned ridle,
                            input bit pressure);
      int unsigned pushed;
      int unsigned n;
      wait_idle();
      csr_write(REG_START, start_m);
      csr_write(REG_FRAME, frame_m);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      if (pressure) begin
         fork
            begin
               stall_hold = 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               stall_hold = 1'b0;
            end
         join_none
      end
      pushed = 0;
      while (pushed < PHASE_BYTES) begin
         queue_stream(n);
         pushed += n;
      end
      wait_idle();
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   // byte sender
   initial begin
      forever begin
         @(negedge clock);
         if (!req_tvalid || req_taken) begin
            if (!reset && byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_byte = byte_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= cur_byte.data;
               req_tlast  <= cur_byte.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : scoreboard
      dims_type got;
      dims_type want;
      dims_type mirror;
      bit       made;
      req_taken = req_tvalid && req_tready;
      if (reset) begin
         rearm_parser();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.width  = rsp_tdata[15:0];
            got.height = rsp_tdata[31:16];
            got.offset = rsp_tdata[63:32];
            if (dims_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d w %0d h %0d off %0d",
                           got.status, got.width, got.height, got.offset);
            end else begin
               want = dims_q.pop_front();
               case (want.status)
                  ST_FOUND:    found_cnt++;
                  ST_BADSTART: badstart_cnt++;
                  default:     noframe_cnt++;
               endcase
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected status %0d w %0d h %0d off %0d, %s",
                              want.status, want.width, want.height, want.offset,
                              $sformatf("got status %0d w %0d h %0d off %0d",
                                        got.status, got.width, got.height, got.offset));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_in++;
            made = parse_byte(req_tdata, req_tlast, mirror);
            if (cur_byte.pinned) begin
               dims_q.push_back(cur_byte.pin);
            end else if (made) begin
               dims_q.push_back(mirror);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               STALL_LIMIT, dims_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : sequencer
      int i;
      rearm_parser();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (i = 0; i < N_DIRECTED; i++) byte_q.push_back(DIRECTED_BYTES[i]);
      streams_sent += 4;
      run_phase(16'h0000, 16'hFFFF, 24, 52, 1'b0);
      run_phase(16'($urandom), 16'($urandom), 52, 24, 1'b0);
      run_phase(16'hFFFF, 16'h0000, 0, 0, 1'b0);
      run_phase(START_MARKER_RST, FRAME_MARKER_RST, 0, 0, 1'b1);
      $display("covered %0d files, %0d bytes over four marker settings and three idle mixes",
               streams_sent, bytes_in);
      $display("results: %0d found, %0d bad start, %0d no frame; %0d mismatches",
               found_cnt, badstart_cnt, noframe_cnt, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
